// ===== rtl/separable_box_blur_core_defines.svh =====
// assertion macros for the separable box blur core
// no dependencies
`ifndef SEPARABLE_BOX_BLUR_CORE_DEFINES_SVH
`define SEPARABLE_BOX_BLUR_CORE_DEFINES_SVH

// same-cycle implication
`define SBB_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sbb check failed");

// next-cycle implication
`define SBB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sbb check failed");

`endif

// ===== rtl/sbb_pkg.sv =====
// shared constants and types of the separable box blur core
// no dependencies
package sbb_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned MAX_RADIUS = 10;

	localparam int unsigned CW   = 13;
	localparam int unsigned PW   = 12;
	localparam int unsigned RW   = 4;
	localparam int unsigned MEMAW = 17;
	localparam int unsigned TW   = 25;
	localparam int unsigned LAGW = 16;
	localparam int unsigned SUMW = 13;
	localparam int unsigned CNTW = 5;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_MODE   = 2'd3;

	localparam logic [CW-1:0] RST_WIDTH  = CW'(640);
	localparam logic [CW-1:0] RST_HEIGHT = CW'(480);
	localparam logic [TW-1:0] RST_TOTAL  = TW'(640 * 480);

	typedef struct packed {
		logic clr_h;
		logic clr_v;
		logic acc_h;
		logic start_h;
		logic start_v;
		logic add_v;
	} ctl_t;

endpackage

// ===== rtl/sbb_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on sbb_pkg
module sbb_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sbb_pkg::SUMW-1:0]   num,
	input  logic [sbb_pkg::CNTW-1:0]   den,
	output logic                       done,
	output logic [sbb_pkg::SUMW-1:0]   quo
);

	logic [sbb_pkg::SUMW-1:0] n_q;
	logic [sbb_pkg::CNTW:0]   rem_q;
	logic [sbb_pkg::CNTW-1:0] den_q;
	logic [3:0]               cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [sbb_pkg::CNTW:0]   trial;
	logic                     ge;

	assign trial = {rem_q[sbb_pkg::CNTW-1:0], n_q[sbb_pkg::SUMW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(sbb_pkg::SUMW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			n_q   <= {n_q[sbb_pkg::SUMW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

// ===== rtl/sbb_lane.sv =====
// one channel lane: row sum, row average, column sum, column average
// depends on sbb_pkg, sbb_div
module sbb_lane (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbb_pkg::ctl_t            ctl,
	input  logic [7:0]               pix,
	input  logic [sbb_pkg::CNTW-1:0] cnt_x,
	input  logic [sbb_pkg::CNTW-1:0] cnt_y,
	output logic [7:0]               res,
	output logic                     done
);

	logic [sbb_pkg::SUMW-1:0] hsum_q;
	logic [sbb_pkg::SUMW-1:0] vsum_q;
	logic [sbb_pkg::SUMW-1:0] quo;

	always_ff @(posedge clk) begin
		if (ctl.clr_h) begin
			hsum_q <= '0;
		end else if (ctl.acc_h) begin
			hsum_q <= hsum_q + {5'd0, pix};
		end
		if (ctl.clr_v) begin
			vsum_q <= '0;
		end else if (ctl.add_v) begin
			vsum_q <= vsum_q + {5'd0, quo[7:0]};
		end
	end

	sbb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start_h | ctl.start_v),
		.num    (ctl.start_h ? hsum_q : vsum_q),
		.den    (ctl.start_h ? cnt_x : cnt_y),
		.done   (done),
		.quo    (quo)
	);

	assign res = quo[7:0];

endmodule

// ===== rtl/separable_box_blur_core.sv =====
// Separable box blur core. Each accepted beat within the frame stores its pixel in
// a line memory; when a result is due the block walks the clipped window, reading
// one stored pixel at a time through states RD and ACC, with three channel lanes
// working in parallel, and divides each row sum and the column sum in a bit-serial
// divider. A beat that gives a result holds off further beats until the result is
// loaded into the output register; nx and ny, the clipped window sizes, run from
// 1 to 21 each. After a register write the block passes through PREP1 and PREP2
// before it takes a pixel. No clearing pass at reset.
// depends on sbb_pkg, sbb_lane, separable_box_blur_core_defines.svh
`include "separable_box_blur_core_defines.svh"

module separable_box_blur_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // in_red_or_grey, in_green, in_blue
	input  logic        s_tuser,   // is_drain
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_red_or_grey, out_green, out_blue
	output logic        m_tlast,   // last_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	typedef enum logic [3:0] {
		IDLE, PREP1, PREP2, ROWSTART, RD, ACC, HDIV, HWAIT, VDIV, VWAIT, OUT
	} state_t;

	state_t state_q;

	logic [sbb_pkg::CW-1:0]   w_q, h_q;
	logic [sbb_pkg::RW-1:0]   r_q;
	logic                     mode_q;
	logic [sbb_pkg::TW-1:0]   total_q, end_q, t_q;
	logic [sbb_pkg::LAGW-1:0] lag_q;
	logic [16:0]              rw_q;
	logic [sbb_pkg::PW-1:0]   oc_q, orow_q;
	logic [sbb_pkg::PW-1:0]   x0_q, x1_q, y1_q, x_q, y_q;
	logic [sbb_pkg::CNTW-1:0] cntx_q, cnty_q;
	logic [sbb_pkg::MEMAW-1:0] rowbase_q;
	logic                     last_q;
	logic                     m_valid_q, m_last_q;
	logic [23:0]              m_data_q;

	logic [23:0] mem [2**sbb_pkg::MEMAW];
	logic [23:0] rdata_q;

	logic                     in_acc, cfg_acc, cfg_known, produce, wr_en, load_out;
	logic [sbb_pkg::MEMAW-1:0] rd_addr;
	logic [sbb_pkg::CW-1:0]   cfg_w, cfg_h, xe, ye;
	logic [sbb_pkg::RW-1:0]   cfg_r;
	logic [sbb_pkg::PW-1:0]   x0_n, x1_n, y0_n, y1_n;
	logic [sbb_pkg::LAGW-1:0] lag_n;
	logic [sbb_pkg::TW-1:0]   t_inc;
	logic [24:0]              rowprod;
	sbb_pkg::ctl_t            ctl;
	logic [7:0]               res0, res1, res2;
	logic                     dn0, dn1, dn2, lanes_done;

	assign s_tready  = (state_q == IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_known = (cfg_index[7:2] == 6'd0);

	assign cfg_w = (cfg_data == '0) ? 13'd1 :
		(cfg_data > 13'(sbb_pkg::MAX_WIDTH)) ? 13'(sbb_pkg::MAX_WIDTH) : cfg_data;
	assign cfg_h = (cfg_data == '0) ? 13'd1 :
		(cfg_data > 13'(sbb_pkg::MAX_HEIGHT)) ? 13'(sbb_pkg::MAX_HEIGHT) : cfg_data;
	assign cfg_r = (cfg_data[3:0] > 4'(sbb_pkg::MAX_RADIUS)) ?
		4'(sbb_pkg::MAX_RADIUS) : cfg_data[3:0];

	assign produce = (t_q >= {9'd0, lag_q}) && (t_q < end_q);
	assign wr_en   = in_acc && (t_q < total_q);
	assign t_inc   = t_q + 25'd1;

	// clipped window around the next output position
	assign x0_n = (oc_q >= {8'd0, r_q}) ? oc_q - {8'd0, r_q} : '0;
	assign xe   = {1'b0, oc_q} + {9'd0, r_q};
	assign x1_n = (xe < w_q) ? xe[11:0] : 12'(w_q - 13'd1);
	assign y0_n = (orow_q >= {8'd0, r_q}) ? orow_q - {8'd0, r_q} : '0;
	assign ye   = {1'b0, orow_q} + {9'd0, r_q};
	assign y1_n = (ye < h_q) ? ye[11:0] : 12'(h_q - 13'd1);

	assign lag_n   = rw_q[15:0] + {12'd0, r_q};
	assign rowprod = {13'd0, y_q} * {12'd0, w_q};
	assign rd_addr = rowbase_q + {5'd0, x_q};

	assign lanes_done = dn0 & dn1 & dn2;
	assign load_out   = (state_q == OUT) && (!m_valid_q || m_tready);

	always_comb begin
		ctl = '0;
		case (state_q)
			IDLE:     ctl.clr_v   = in_acc && produce;
			ROWSTART: ctl.clr_h   = 1'b1;
			ACC:      ctl.acc_h   = 1'b1;
			HDIV:     ctl.start_h = 1'b1;
			HWAIT:    ctl.add_v   = lanes_done;
			VDIV:     ctl.start_v = 1'b1;
			default:  ctl = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[t_q[sbb_pkg::MEMAW-1:0]] <= s_tuser ? 24'd0 : s_tdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			w_q       <= sbb_pkg::RST_WIDTH;
			h_q       <= sbb_pkg::RST_HEIGHT;
			r_q       <= '0;
			mode_q    <= 1'b1;
			total_q   <= sbb_pkg::RST_TOTAL;
			end_q     <= sbb_pkg::RST_TOTAL;
			lag_q     <= '0;
			rw_q      <= '0;
			t_q       <= '0;
			oc_q      <= '0;
			orow_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && !load_out) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cfg_acc && cfg_known) begin
						case (cfg_index[1:0])
							sbb_pkg::REG_WIDTH:  w_q    <= cfg_w;
							sbb_pkg::REG_HEIGHT: h_q    <= cfg_h;
							sbb_pkg::REG_RADIUS: r_q    <= cfg_r;
							sbb_pkg::REG_MODE:   mode_q <= cfg_data[0];
							default:             mode_q <= mode_q;
						endcase
						t_q     <= '0;
						oc_q    <= '0;
						orow_q  <= '0;
						state_q <= PREP1;
					end else if (in_acc) begin
						t_q <= (t_inc >= end_q) ? '0 : t_inc;
						if (t_inc >= end_q) begin
							oc_q   <= '0;
							orow_q <= '0;
						end else if (produce) begin
							if ({1'b0, oc_q} == w_q - 13'd1) begin
								oc_q   <= '0;
								orow_q <= orow_q + 12'd1;
							end else begin
								oc_q <= oc_q + 12'd1;
							end
						end
						if (produce) begin
							x0_q    <= x0_n;
							x1_q    <= x1_n;
							y1_q    <= y1_n;
							x_q     <= x0_n;
							y_q     <= y0_n;
							cntx_q  <= 5'(x1_n - x0_n + 12'd1);
							cnty_q  <= 5'(y1_n - y0_n + 12'd1);
							last_q  <= (t_inc == end_q);
							state_q <= ROWSTART;
						end
					end
				end
				PREP1: begin
					total_q <= {12'd0, w_q} * {12'd0, h_q};
					rw_q    <= {13'd0, r_q} * {4'd0, w_q};
					state_q <= PREP2;
				end
				PREP2: begin
					lag_q   <= lag_n;
					end_q   <= total_q + {9'd0, lag_n};
					state_q <= IDLE;
				end
				ROWSTART: begin
					rowbase_q <= rowprod[sbb_pkg::MEMAW-1:0];
					x_q       <= x0_q;
					state_q   <= RD;
				end
				RD: state_q <= ACC;
				ACC: begin
					if (x_q == x1_q) begin
						state_q <= HDIV;
					end else begin
						x_q     <= x_q + 12'd1;
						state_q <= RD;
					end
				end
				HDIV: state_q <= HWAIT;
				HWAIT: begin
					if (lanes_done) begin
						if (y_q == y1_q) begin
							state_q <= VDIV;
						end else begin
							y_q     <= y_q + 12'd1;
							state_q <= ROWSTART;
						end
					end
				end
				VDIV: state_q <= VWAIT;
				VWAIT: begin
					if (lanes_done) begin
						state_q <= OUT;
					end
				end
				OUT: begin
					if (load_out) begin
						m_valid_q <= 1'b1;
						m_data_q  <= mode_q ? {res2, res1, res0} : {16'd0, res0};
						m_last_q  <= last_q;
						state_q   <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	sbb_lane u_lane_r (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pix(rdata_q[7:0]),
		.cnt_x(cntx_q), .cnt_y(cnty_q), .res(res0), .done(dn0)
	);

	sbb_lane u_lane_g (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pix(rdata_q[15:8]),
		.cnt_x(cntx_q), .cnt_y(cnty_q), .res(res1), .done(dn1)
	);

	sbb_lane u_lane_b (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pix(rdata_q[23:16]),
		.cnt_x(cntx_q), .cnt_y(cnty_q), .res(res2), .done(dn2)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	`SBB_ASSERT_NOW(a_x_in_window, clk, arst_n, state_q == RD, (x_q >= x0_q) && (x_q <= x1_q))
	`SBB_ASSERT_NOW(a_y_in_window, clk, arst_n, state_q == ROWSTART, y_q <= y1_q)
	`SBB_ASSERT_NOW(a_lanes_lockstep, clk, arst_n, dn0, dn1 && dn2)
	`SBB_ASSERT_NEXT(a_out_loaded, clk, arst_n, load_out, m_tvalid && (state_q == IDLE))

endmodule
